/* hdl/pnse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnse_pkg: shared types and constants of the nested string extractor
// Parse phases, result status codes, the parser state record and the
// length limit of one message.
// ----------------------------------------------------------------------------
package pnse_pkg;

    localparam int unsigned MAX_MSG_LEN = 32'd65535;
    localparam int unsigned POS_W       = 16;
    localparam int unsigned SHIFT_W     = 4;
    localparam logic [SHIFT_W-1:0] VARINT_LAST_IDX = 4'd9;
    localparam logic [2:0] WIRE_LEN_DELIM = 3'd2;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_OTAG  = 9'b000000010,
        PH_OLEN  = 9'b000000100,
        PH_OSKIP = 9'b000001000,
        PH_ITAG  = 9'b000010000,
        PH_ILEN  = 9'b000100000,
        PH_ISKIP = 9'b001000000,
        PH_ID    = 9'b010000000,
        PH_DONE  = 9'b100000000
    } phase_t;

    typedef enum logic [1:0] {
        ST_ID    = 2'd0,
        ST_NOID  = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef struct packed {
        phase_t             phase;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   msg_end;
        logic [POS_W-1:0]   outer_end;
        logic [POS_W-1:0]   inner_end;
        logic [POS_W-1:0]   acc_lo;
        logic               acc_hi;
        logic [SHIFT_W-1:0] shift;
        logic               field_one;
        logic               inside_outer;
        logic [POS_W-1:0]   id_left;
    } state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       last;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:        PH_IDLE,
        pos:          '0,
        msg_end:      '0,
        outer_end:    '0,
        inner_end:    '0,
        acc_lo:       '0,
        acc_hi:       1'b0,
        shift:        '0,
        field_one:    1'b0,
        inside_outer: 1'b0,
        id_left:      '0
    };

endpackage
`default_nettype wire

/* hdl/pnse_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnse_ifs: request and result channels of the nested string extractor
// Each channel carries valid, ready and the payload of one item.
// ----------------------------------------------------------------------------
interface pnse_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  data_byte;
    logic [15:0] msg_length;

    modport source (output valid, req_type, data_byte, msg_length, input ready);
    modport sink   (input valid, req_type, data_byte, msg_length, output ready);
endinterface

interface pnse_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, out_byte, status, last, input ready);
    modport sink   (input valid, out_byte, status, last, output ready);
endinterface
`default_nettype wire

/* hdl/pnse_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnse_step: next-state logic of the wire-format parser
// Takes the parser state and one request item and produces the next state
// and at most one result item.
// ----------------------------------------------------------------------------
module pnse_step (
    input  var pnse_pkg::state_t  st,
    input  wire logic             req_type,
    input  wire logic [7:0]       data_byte,
    input  wire logic [15:0]      msg_length,
    output var pnse_pkg::state_t  st_next,
    output logic                  res_valid,
    output var pnse_pkg::result_t res
);

    typedef struct packed {
        pnse_pkg::state_t  s;
        logic              fin;
        pnse_pkg::status_t code;
    } settle_t;

    // Resolves record boundaries reached at the current position.
    function automatic settle_t settle(pnse_pkg::state_t s_in);
        settle_t r;
        r.s    = s_in;
        r.fin  = 1'b0;
        r.code = pnse_pkg::ST_NOID;
        if (r.s.phase == pnse_pkg::PH_ISKIP && r.s.pos == r.s.inner_end)
            r.s.phase = pnse_pkg::PH_ITAG;
        if (r.s.phase == pnse_pkg::PH_ITAG && r.s.shift == '0 && r.s.pos == r.s.outer_end)
        begin
            r.s.inside_outer = 1'b0;
            r.s.phase        = pnse_pkg::PH_OTAG;
        end
        if (r.s.phase == pnse_pkg::PH_OSKIP && r.s.pos == r.s.outer_end)
            r.s.phase = pnse_pkg::PH_OTAG;
        if (r.s.phase == pnse_pkg::PH_OTAG && r.s.shift == '0 && r.s.pos == r.s.msg_end)
        begin
            r.fin  = 1'b1;
            r.code = pnse_pkg::ST_NOID;
        end
        else if ((r.s.phase == pnse_pkg::PH_ITAG || r.s.phase == pnse_pkg::PH_ILEN)
                 && r.s.pos == r.s.outer_end)
        begin
            r.fin  = 1'b1;
            r.code = pnse_pkg::ST_BAD;
        end
        else if ((r.s.phase == pnse_pkg::PH_OTAG || r.s.phase == pnse_pkg::PH_OLEN)
                 && r.s.pos == r.s.msg_end)
        begin
            r.fin  = 1'b1;
            r.code = pnse_pkg::ST_BAD;
        end
        return r;
    endfunction

    logic [pnse_pkg::POS_W-1:0] lo_new;
    logic                       hi_new;
    logic [pnse_pkg::POS_W-1:0] pos_inc;
    logic [pnse_pkg::POS_W-1:0] len_sat;
    logic                       len_bad_msg;
    logic                       len_bad_outer;
    pnse_pkg::state_t           st_w;
    settle_t                    sr;
    logic                       do_settle;
    logic                       fin;
    pnse_pkg::status_t          code;
    logic                       emit_id;

    // The varint value is kept as its low sixteen bits and a flag for any
    // higher bit set, which is all that tag and length checks need.
    always_comb
    begin
        lo_new = st.acc_lo;
        hi_new = st.acc_hi;
        if (st.shift == 4'd0)
            lo_new[6:0] = st.acc_lo[6:0] | data_byte[6:0];
        else if (st.shift == 4'd1)
            lo_new[13:7] = st.acc_lo[13:7] | data_byte[6:0];
        else if (st.shift == 4'd2)
        begin
            lo_new[15:14] = st.acc_lo[15:14] | data_byte[1:0];
            hi_new        = st.acc_hi | (|data_byte[6:2]);
        end
        else if (st.shift inside {[4'd3:4'd8]})
            hi_new = st.acc_hi | (|data_byte[6:0]);
        else
            hi_new = st.acc_hi | data_byte[0];
    end

    assign pos_inc       = st.pos + 16'd1;
    assign len_sat       = (32'(msg_length) > pnse_pkg::MAX_MSG_LEN)
                           ? pnse_pkg::POS_W'(pnse_pkg::MAX_MSG_LEN) : msg_length;
    assign len_bad_msg   = hi_new || (lo_new > (st.msg_end - pos_inc));
    assign len_bad_outer = hi_new || (lo_new > (st.outer_end - pos_inc));

    always_comb
    begin
        st_w      = st;
        do_settle = 1'b0;
        fin       = 1'b0;
        code      = pnse_pkg::ST_NOID;
        emit_id   = 1'b0;
        sr        = '{s: st, fin: 1'b0, code: pnse_pkg::ST_NOID};
        if (!req_type)
        begin
            st_w         = pnse_pkg::STATE_RESET;
            st_w.msg_end = len_sat;
            st_w.phase   = pnse_pkg::PH_OTAG;
            do_settle    = 1'b1;
        end
        else if (st.phase != pnse_pkg::PH_IDLE && st.phase != pnse_pkg::PH_DONE)
        begin
            st_w.pos = pos_inc;
            if (st.phase == pnse_pkg::PH_ID)
            begin
                st_w.id_left = st.id_left - 16'd1;
                emit_id      = 1'b1;
                if (st_w.id_left == '0)
                    st_w.phase = pnse_pkg::PH_DONE;
            end
            else if (st.phase inside {pnse_pkg::PH_OTAG, pnse_pkg::PH_OLEN,
                                      pnse_pkg::PH_ITAG, pnse_pkg::PH_ILEN})
            begin
                st_w.acc_lo = lo_new;
                st_w.acc_hi = hi_new;
                if (data_byte[7])
                begin
                    if (st.shift >= pnse_pkg::VARINT_LAST_IDX)
                    begin
                        fin  = 1'b1;
                        code = pnse_pkg::ST_BAD;
                    end
                    else
                    begin
                        st_w.shift = st.shift + 4'd1;
                        do_settle  = 1'b1;
                    end
                end
                else
                begin
                    st_w.acc_lo = '0;
                    st_w.acc_hi = 1'b0;
                    st_w.shift  = '0;
                    case (st.phase)
                        pnse_pkg::PH_OTAG, pnse_pkg::PH_ITAG:
                        begin
                            if (lo_new[2:0] != pnse_pkg::WIRE_LEN_DELIM)
                            begin
                                fin  = 1'b1;
                                code = pnse_pkg::ST_BAD;
                            end
                            else
                            begin
                                st_w.field_one = !hi_new && (lo_new[15:3] == 13'd1);
                                st_w.phase     = (st.phase == pnse_pkg::PH_OTAG)
                                                 ? pnse_pkg::PH_OLEN : pnse_pkg::PH_ILEN;
                                do_settle      = 1'b1;
                            end
                        end
                        pnse_pkg::PH_OLEN:
                        begin
                            if (len_bad_msg)
                            begin
                                fin  = 1'b1;
                                code = pnse_pkg::ST_BAD;
                            end
                            else
                            begin
                                st_w.outer_end = pos_inc + lo_new;
                                if (st.field_one)
                                begin
                                    st_w.inside_outer = 1'b1;
                                    st_w.phase        = pnse_pkg::PH_ITAG;
                                end
                                else
                                    st_w.phase = pnse_pkg::PH_OSKIP;
                                do_settle = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (len_bad_outer)
                            begin
                                fin  = 1'b1;
                                code = pnse_pkg::ST_BAD;
                            end
                            else if (st.field_one)
                            begin
                                if (lo_new == '0)
                                begin
                                    fin  = 1'b1;
                                    code = pnse_pkg::ST_NOID;
                                end
                                else
                                begin
                                    st_w.id_left = lo_new;
                                    st_w.phase   = pnse_pkg::PH_ID;
                                end
                            end
                            else
                            begin
                                st_w.inner_end = pos_inc + lo_new;
                                st_w.phase     = pnse_pkg::PH_ISKIP;
                                do_settle      = 1'b1;
                            end
                        end
                    endcase
                end
            end
            else
                do_settle = 1'b1;
        end

        if (do_settle)
        begin
            sr   = settle(st_w);
            st_w = sr.s;
            fin  = sr.fin;
            code = sr.code;
        end
        if (fin)
            st_w.phase = pnse_pkg::PH_DONE;
    end

    assign st_next      = st_w;
    assign res_valid    = fin || emit_id;
    assign res.out_byte = emit_id ? data_byte : 8'd0;
    assign res.status   = emit_id ? pnse_pkg::ST_ID : code;
    assign res.last     = emit_id ? (st_w.id_left == '0) : 1'b1;

endmodule
`default_nettype wire

/* hdl/protobuf_nested_string_extractor_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// protobuf_nested_string_extractor_core: nested id string extractor
// Walks a length-delimited wire-format message one byte per item and emits
// the bytes of the first inner field-1 string of an outer field-1 record.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload                         Item
// req      in         req_type, data_byte, msg_length begin of message or byte
// res      out        out_byte, status, last          id byte or final outcome
//
// Every item is processed in the cycle it is accepted; one item per cycle while req.ready is high.
// A result is held in an output register and is offered on res in the cycle after its item.
// The parser state updates directly from the accepted item, so the rate is
// set only by the single pass through the next-state logic.
// Reset clears the parser to idle and empties the output register.
// req.ready drops only while a held result is stalled by res.ready.
// ----------------------------------------------------------------------------
module protobuf_nested_string_extractor_core (
    input  wire logic clk,
    input  wire logic rst_n,
    pnse_req_if.sink  req,
    pnse_res_if.source res
);

    pnse_pkg::state_t  st_reg;
    pnse_pkg::state_t  st_next;
    logic              step_valid;
    pnse_pkg::result_t step_res;
    logic              in_acc;
    logic              out_valid_reg;
    logic              out_valid_next;
    pnse_pkg::result_t out_reg;

    pnse_step u_step (
        .st         (st_reg),
        .req_type   (req.req_type),
        .data_byte  (req.data_byte),
        .msg_length (req.msg_length),
        .st_next    (st_next),
        .res_valid  (step_valid),
        .res        (step_res)
    );

    assign req.ready = !out_valid_reg || res.ready;
    assign in_acc    = req.valid && req.ready;

    always_comb
    begin
        if (out_valid_reg && !res.ready)
            out_valid_next = 1'b1;
        else
            out_valid_next = in_acc && step_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= pnse_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_acc)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && step_valid)
            out_reg <= step_res;
    end

    assign res.valid    = out_valid_reg;
    assign res.out_byte = out_reg.out_byte;
    assign res.status   = out_reg.status;
    assign res.last     = out_reg.last;

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(st_reg.phase))
        else $error("parser phase is not one-hot");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pos <= st_reg.msg_end)
        else $error("byte position passed the message end");

    a_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && req.req_type
         && (st_reg.phase == pnse_pkg::PH_IDLE || st_reg.phase == pnse_pkg::PH_DONE))
        |-> !step_valid)
        else $error("result produced for an ignored byte");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && step_valid && step_res.last) |-> st_next.phase == pnse_pkg::PH_DONE)
        else $error("final result did not end the message");

    a_outcome_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != pnse_pkg::ST_ID) |-> out_reg.last)
        else $error("outcome result without last");

    a_inside_outer: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.inside_outer |-> (st_reg.phase == pnse_pkg::PH_ITAG
            || st_reg.phase == pnse_pkg::PH_ILEN || st_reg.phase == pnse_pkg::PH_ISKIP
            || st_reg.phase == pnse_pkg::PH_ID || st_reg.phase == pnse_pkg::PH_DONE))
        else $error("inside an outer record in an outer phase");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression of protobuf_nested_string_extractor_core
// Drives begin and byte items into the request channel and checks every item
// on the result channel against an in-bench parser of the wire format. A
// short directed part covers idle bytes, restarts, id extraction, missing or
// empty ids and malformed records. Random messages follow, mostly well formed
// with random content, some truncated, padded, corrupted or abandoned, under
// four idling phases of sender and receiver.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam bit REQ_BEGIN = 1'b0;
    localparam bit REQ_BYTE = 1'b1;

    logic clk;
    logic rst_n;

    pnse_req_if req_ch();
    pnse_res_if res_ch();

    protobuf_nested_string_extractor_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    int src_idle_pct;
    int sink_stall_pct;
    int mismatch_count;
    int sent_items;
    int cycle_count;

    pnse_pkg::result_t expected_outcomes[$];
    logic [7:0] msg_bytes[$];
    logic [7:0] rec_bytes[$];

    pnse_pkg::phase_t phase;
    int unsigned pos;
    int unsigned msg_end;
    int unsigned outer_end;
    int unsigned inner_end;
    logic [63:0] acc;
    int          nbytes;
    bit          field_one;
    bit          in_outer;
    int unsigned id_left;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void reset_parser();
        phase = pnse_pkg::PH_IDLE;
        pos = 0;
        msg_end = 0;
        outer_end = 0;
        inner_end = 0;
        acc = '0;
        nbytes = 0;
        field_one = 1'b0;
        in_outer = 1'b0;
        id_left = 0;
    endfunction

    function automatic bit end_message(input pnse_pkg::status_t st,
                                       output pnse_pkg::result_t r);
        phase = pnse_pkg::PH_DONE;
        r.out_byte = 8'h00;
        r.status = st;
        r.last = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit settle_parse(output pnse_pkg::result_t r);
        r = '0;
        if (phase == pnse_pkg::PH_ISKIP && pos == inner_end)
            phase = pnse_pkg::PH_ITAG;
        if (phase == pnse_pkg::PH_ITAG && nbytes == 0 && pos == outer_end)
        begin
            in_outer = 1'b0;
            phase = pnse_pkg::PH_OTAG;
        end
        if (phase == pnse_pkg::PH_OSKIP && pos == outer_end)
            phase = pnse_pkg::PH_OTAG;
        if (phase == pnse_pkg::PH_OTAG && nbytes == 0 && pos == msg_end)
            return end_message(pnse_pkg::ST_NOID, r);
        if ((phase == pnse_pkg::PH_ITAG || phase == pnse_pkg::PH_ILEN) && pos == outer_end)
            return end_message(pnse_pkg::ST_BAD, r);
        if ((phase == pnse_pkg::PH_OTAG || phase == pnse_pkg::PH_OLEN) && pos == msg_end)
            return end_message(pnse_pkg::ST_BAD, r);
        return 1'b0;
    endfunction

    function automatic bit parse_wire_byte(input bit rt, input logic [7:0] b,
                                           input logic [15:0] len,
                                           output pnse_pkg::result_t r);
        logic [63:0] v;
        r = '0;
        if (rt == REQ_BEGIN)
        begin
            reset_parser();
            msg_end = (int'(len) > int'(pnse_pkg::MAX_MSG_LEN))
                      ? pnse_pkg::MAX_MSG_LEN : int'(len);
            phase = pnse_pkg::PH_OTAG;
            return settle_parse(r);
        end
        if (phase == pnse_pkg::PH_IDLE || phase == pnse_pkg::PH_DONE)
            return 1'b0;
        pos++;
        if (phase == pnse_pkg::PH_ID)
        begin
            id_left--;
            r.out_byte = b;
            r.status = pnse_pkg::ST_ID;
            r.last = (id_left == 0);
            if (id_left == 0)
                phase = pnse_pkg::PH_DONE;
            return 1'b1;
        end
        if (phase == pnse_pkg::PH_OTAG || phase == pnse_pkg::PH_OLEN
            || phase == pnse_pkg::PH_ITAG || phase == pnse_pkg::PH_ILEN)
        begin
            acc = acc | (64'(b[6:0]) << (7 * nbytes));
            if (b[7])
            begin
                if (nbytes >= int'(pnse_pkg::VARINT_LAST_IDX))
                    return end_message(pnse_pkg::ST_BAD, r);
                nbytes++;
                return settle_parse(r);
            end
            v = acc;
            acc = '0;
            nbytes = 0;
            case (phase)
                pnse_pkg::PH_OTAG, pnse_pkg::PH_ITAG:
                begin
                    if (v[2:0] != pnse_pkg::WIRE_LEN_DELIM)
                        return end_message(pnse_pkg::ST_BAD, r);
                    field_one = ((v >> 3) == 64'd1);
                    if (phase == pnse_pkg::PH_OTAG)
                        phase = pnse_pkg::PH_OLEN;
                    else
                        phase = pnse_pkg::PH_ILEN;
                end
                pnse_pkg::PH_OLEN:
                begin
                    if (v > 64'(msg_end - pos))
                        return end_message(pnse_pkg::ST_BAD, r);
                    outer_end = pos + v[31:0];
                    if (field_one)
                    begin
                        in_outer = 1'b1;
                        phase = pnse_pkg::PH_ITAG;
                    end
                    else
                    begin
                        phase = pnse_pkg::PH_OSKIP;
                    end
                end
                default:
                begin
                    if (v > 64'(outer_end - pos))
                        return end_message(pnse_pkg::ST_BAD, r);
                    if (field_one)
                    begin
                        if (v == 0)
                            return end_message(pnse_pkg::ST_NOID, r);
                        id_left = v[31:0];
                        phase = pnse_pkg::PH_ID;
                        return 1'b0;
                    end
                    inner_end = pos + v[31:0];
                    phase = pnse_pkg::PH_ISKIP;
                end
            endcase
        end
        return settle_parse(r);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic send_item(input bit rt, input logic [7:0] b, input logic [15:0] len);
        pnse_pkg::result_t r;
        bit has_result;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.data_byte <= b;
        req_ch.msg_length <= len;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        has_result = parse_wire_byte(rt, b, len, r);
        if (has_result)
            expected_outcomes.insert(expected_outcomes.size(), r);
        sent_items++;
        @(negedge clk);
    endtask

    always @(negedge clk)
        res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin : check_results
        pnse_pkg::result_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result byte %0h status %0d last %0b",
                                          res_ch.out_byte, res_ch.status, res_ch.last));
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (res_ch.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %0h, expected %0h",
                                              res_ch.out_byte, want.out_byte));
                if (res_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              res_ch.status, want.status));
                if (res_ch.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              res_ch.last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("protobuf_nested_string_extractor_core regression: fail");
            $finish;
        end
    end

    function automatic void push_byte(input logic [7:0] b, input bit into_record);
        if (into_record)
            rec_bytes.insert(rec_bytes.size(), b);
        else
            msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    // Some varints are padded with redundant continuation bytes, and a few
    // are padded past the ten-byte limit.
    function automatic void add_varint(input logic [63:0] v, input bit into_record);
        int pad;
        logic [7:0] b;
        pad = 0;
        if ($urandom_range(99) < 3)
            pad = 10;
        else if ($urandom_range(99) < 15)
            pad = $urandom_range(1, 3);
        do
        begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0 || pad > 0)
                b[7] = 1'b1;
            push_byte(b, into_record);
        end
        while (v != 0);
        for (int i = 1; i < pad; i++)
            push_byte(8'h80, into_record);
        if (pad > 0)
            push_byte(8'h00, into_record);
    endfunction

    function automatic logic [60:0] pick_field();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 61'd1;
            5, 6: return 61'd2;
            7: return 61'd0;
            8: return 61'($urandom_range(3, 5000));
            default: return 61'({$urandom, $urandom});
        endcase
    endfunction

    function automatic void add_key(input logic [60:0] fld, input bit into_record);
        logic [2:0] wt;
        wt = ($urandom_range(99) < 4) ? 3'($urandom_range(7)) : pnse_pkg::WIRE_LEN_DELIM;
        add_varint({fld, wt}, into_record);
    endfunction

    function automatic void build_message();
        int n_pay;
        logic [60:0] fld;
        msg_bytes.delete();
        repeat ($urandom_range(0, 3))
        begin
            rec_bytes.delete();
            fld = pick_field();
            if (fld == 1)
            begin
                repeat ($urandom_range(0, 3))
                begin
                    add_key(pick_field(), 1'b1);
                    n_pay = $urandom_range(0, 6);
                    add_varint(64'(n_pay), 1'b1);
                    repeat (n_pay)
                        push_byte(8'($urandom), 1'b1);
                end
            end
            else
            begin
                repeat ($urandom_range(0, 5))
                    push_byte(8'($urandom), 1'b1);
            end
            add_key(fld, 1'b0);
            add_varint(64'(rec_bytes.size()), 1'b0);
            foreach (rec_bytes[i])
                msg_bytes.insert(msg_bytes.size(), rec_bytes[i]);
        end
    endfunction

    task automatic send_random_message();
        int mode;
        int n_send;
        int len;
        build_message();
        len = msg_bytes.size();
        n_send = msg_bytes.size();
        mode = $urandom_range(99);
        if (mode >= 70 && mode < 80)
        begin
            len = $urandom_range(0, len);
        end
        else if (mode >= 80 && mode < 85)
        begin
            len = len + $urandom_range(1, 4);
        end
        else if (mode >= 85 && mode < 90 && n_send > 0)
        begin
            msg_bytes[$urandom_range(0, n_send - 1)] = 8'($urandom);
        end
        else if (mode >= 90 && mode < 95)
        begin
            n_send = $urandom_range(0, n_send);
        end
        else if (mode >= 95)
        begin
            len = $urandom_range(0, 65535);
            n_send = $urandom_range(0, 8);
            msg_bytes.delete();
            repeat (n_send)
                msg_bytes.insert(msg_bytes.size(), 8'($urandom));
        end
        send_item(REQ_BEGIN, 8'($urandom), 16'(len));
        for (int i = 0; i < n_send; i++)
            send_item(REQ_BYTE, msg_bytes[i], 16'($urandom));
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 3))
                send_item(REQ_BYTE, 8'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_idle_and_restart();
        send_item(REQ_BYTE, 8'h0a, 16'h0000);
        send_item(REQ_BEGIN, 8'h00, 16'h0000);
        send_item(REQ_BEGIN, 8'hff, 16'hffff);
        send_item(REQ_BYTE, 8'h0a, 16'hffff);
    endtask

    task automatic test_id_extraction();
        send_item(REQ_BEGIN, 8'h00, 16'd6);
        send_item(REQ_BYTE, 8'h0a, 16'h0000);
        send_item(REQ_BYTE, 8'h04, 16'h0000);
        send_item(REQ_BYTE, 8'h0a, 16'h0000);
        send_item(REQ_BYTE, 8'h02, 16'h0000);
        send_item(REQ_BYTE, 8'hff, 16'h0000);
        send_item(REQ_BYTE, 8'h00, 16'h0000);
        send_item(REQ_BYTE, 8'h55, 16'h0000);
    endtask

    task automatic test_missing_id();
        send_item(REQ_BEGIN, 8'h00, 16'd4);
        send_item(REQ_BYTE, 8'h0a, 16'h0000);
        send_item(REQ_BYTE, 8'h02, 16'h0000);
        send_item(REQ_BYTE, 8'h0a, 16'h0000);
        send_item(REQ_BYTE, 8'h00, 16'h0000);
        send_item(REQ_BEGIN, 8'h00, 16'd2);
        send_item(REQ_BYTE, 8'h12, 16'h0000);
        send_item(REQ_BYTE, 8'h00, 16'h0000);
    endtask

    task automatic test_malformed();
        send_item(REQ_BEGIN, 8'h00, 16'd1);
        send_item(REQ_BYTE, 8'h08, 16'h0000);
        send_item(REQ_BEGIN, 8'h00, 16'd2);
        send_item(REQ_BYTE, 8'h0a, 16'h0000);
        send_item(REQ_BYTE, 8'h05, 16'h0000);
        send_item(REQ_BEGIN, 8'h00, 16'd1);
        send_item(REQ_BYTE, 8'h0a, 16'h0000);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
        int start;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        start = sent_items;
        while (sent_items - start < count)
            send_random_message();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_BEGIN;
        req_ch.data_byte = 8'h00;
        req_ch.msg_length = 16'h0000;
        res_ch.ready = 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        mismatch_count = 0;
        sent_items = 0;
        cycle_count = 0;
        reset_parser();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_idle_and_restart();
        test_id_extraction();
        test_missing_id();
        test_malformed();
        test_random_traffic(0, 0, 200);
        test_random_traffic(72, 0, 200);
        test_random_traffic(0, 72, 200);
        test_random_traffic(21, 21, 200);

        req_ch.valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("protobuf_nested_string_extractor_core regression: pass");
        else
            $display("protobuf_nested_string_extractor_core regression: fail");
        $finish;
    end

endmodule
